// ----- rtl/core/cubic_bezier_ease_eval_macros.svh -----
// ----------------------------------------------------------------------------
// cubic_bezier_ease_eval_macros
// assertion macros used by the easing curve rtl
// ----------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_EASE_EVAL_MACROS_SVH
`define CUBIC_BEZIER_EASE_EVAL_MACROS_SVH

`ifndef SYNTHESIS

// checked property, quiet while reset is applied
`define CBEE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cbee assertion failed");

// checked property, also evaluated during reset
`define CBEE_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("cbee assertion failed");

`else

`define CBEE_ASSERT(lbl, clk, rst_n, prop)
`define CBEE_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ----- rtl/core/cbee_pkg.sv -----
// ----------------------------------------------------------------------------
// cbee_pkg
// types, fixed-point formats and curve coefficients of the easing evaluator
// ----------------------------------------------------------------------------
`default_nettype none

package cbee_pkg;

    // fraction bits of progress and eased (q2.15 in, q1.15 out)
    localparam int FRAC_BITS = 15;
    // internal fraction bits (q6.30 accumulator, q1.30 curve parameter)
    localparam int IQ = 30;
    // accumulator width, signed
    localparam int AW = 37;
    // curve parameter width, unsigned 0..1.0
    localparam int SW = IQ + 1;
    // dividend width of the newton quotient
    localparam int NW = 64;
    // extended input width for the clamp
    localparam int PW = 26;

    localparam logic [SW-1:0] S_ONE = SW'(1) << IQ;

    // power-form coefficients times 2^30
    localparam logic signed [AW-1:0] KX1 = 37'sd1030792151;
    localparam logic signed [AW-1:0] KX2 = -37'sd2061584302;
    localparam logic signed [AW-1:0] KX3 = 37'sd2104533975;
    localparam logic signed [AW-1:0] KD0 = 37'sd1030792151;
    localparam logic signed [AW-1:0] KD1 = -37'sd4123168604;
    localparam logic signed [AW-1:0] KD2 = 37'sd6313601925;
    localparam logic signed [AW-1:0] KY1 = 37'sd2319282340;
    localparam logic signed [AW-1:0] KY2 = -37'sd1417339208;
    localparam logic signed [AW-1:0] KY3 = 37'sd171798692;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_ADD,
        ST_POST,
        ST_DIV,
        ST_UPD
    } state_t;

    typedef enum logic [1:0] {
        POLY_X,
        POLY_DX,
        POLY_Y
    } poly_t;

    // leading coefficient of each horner chain
    function automatic logic signed [AW-1:0] lead_coef(input poly_t p);
        logic signed [AW-1:0] c;
        case (p)
            POLY_X:  c = KX3;
            POLY_DX: c = KD2;
            POLY_Y:  c = KY3;
            default: c = '0;
        endcase
        return c;
    endfunction

    // coefficient added after multiply number k
    function automatic logic signed [AW-1:0] add_coef(input poly_t p, input logic [1:0] k);
        logic signed [AW-1:0] c;
        c = '0;
        case (p)
            POLY_X:  c = (k == 2'd0) ? KX2 : ((k == 2'd1) ? KX1 : '0);
            POLY_DX: c = (k == 2'd0) ? KD1 : KD0;
            POLY_Y:  c = (k == 2'd0) ? KY2 : ((k == 2'd1) ? KY1 : '0);
            default: c = '0;
        endcase
        return c;
    endfunction

    // multiplies per chain, as the last index
    function automatic logic [1:0] last_step(input poly_t p);
        logic [1:0] n;
        case (p)
            POLY_DX: n = 2'd1;
            default: n = 2'd2;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/cbee_mul.sv -----
// ----------------------------------------------------------------------------
// cbee_mul
// shared q6.30 by q1.30 multiplier, rounds half away from zero, registered product
// ----------------------------------------------------------------------------
`default_nettype none

module cbee_mul
(
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic signed [cbee_pkg::AW-1:0] a,
    input  wire logic [cbee_pkg::SW-1:0]        b,
    output logic signed [cbee_pkg::AW-1:0]      prod
);
    import cbee_pkg::*;

    localparam logic [AW+SW-1:0] RND = (AW+SW)'(1) << (IQ - 1);

    logic [AW-1:0]           mag;
    logic [AW+SW-1:0]        full;
    logic [AW-1:0]           rmag;
    logic signed [AW-1:0]    prod_next;
    logic signed [AW-1:0]    prod_reg;

    // magnitude product, rounded and re-signed
    always_comb
    begin
        mag       = a[AW-1] ? AW'(-a) : AW'(a);
        full      = (AW+SW)'(mag) * (AW+SW)'(b) + RND;
        rmag      = full[IQ +: AW];
        prod_next = a[AW-1] ? -$signed(rmag) : $signed(rmag);
    end

    // product register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ----- rtl/core/cbee_div.sv -----
// ----------------------------------------------------------------------------
// cbee_div
// serial restoring divider for the newton quotient, one bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module cbee_div
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic signed [cbee_pkg::AW-1:0] num,
    input  wire logic signed [cbee_pkg::AW-1:0] den,
    output logic                               done,
    output logic signed [cbee_pkg::NW:0]       quo
);
    import cbee_pkg::*;

    localparam int RW = AW + 1;
    localparam int CW = $clog2(NW + 1);
    localparam logic [AW-1:0] SAT = AW'(4) << IQ;

    logic [AW-1:0]  un;
    logic [AW-1:0]  ud;
    logic [NW-1:0]  dividend;
    logic [RW:0]    shifted;
    logic           ge;

    logic [NW-1:0]  num_reg,  num_next;
    logic [RW-1:0]  rem_reg,  rem_next;
    logic [NW-1:0]  q_reg,    q_next;
    logic [AW-1:0]  den_reg,  den_next;
    logic           neg_reg,  neg_next;
    logic [CW-1:0]  cnt_reg,  cnt_next;
    logic           run_reg,  run_next;
    logic           done_reg, done_next;

    // operand magnitudes, saturated residual, rounding term
    always_comb
    begin
        un = num[AW-1] ? AW'(-num) : AW'(num);
        ud = den[AW-1] ? AW'(-den) : AW'(den);
        if (un > SAT)
        begin
            un = SAT;
        end
        dividend = (NW'(un) << IQ) + NW'(ud >> 1);
    end

    // one restoring step
    always_comb
    begin
        shifted = {rem_reg, num_reg[NW-1]};
        ge      = shifted >= (RW+1)'(den_reg);
    end

    // sequencing
    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next = dividend;
            rem_next = '0;
            q_next   = '0;
            den_next = ud;
            neg_next = num[AW-1] ^ den[AW-1];
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = ge ? RW'(shifted - (RW+1)'(den_reg)) : RW'(shifted);
            q_next   = {q_reg[NW-2:0], ge};
            num_next = num_reg << 1;
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(NW - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quo  = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});

endmodule

`default_nettype wire

// ----- rtl/core/cubic_bezier_ease_eval.sv -----
// each newton step evaluates x(s) and its derivative on the shared multiplier,
// waits on the serial divider for the quotient, then updates s; y(s) is
// evaluated after the last step, and a flat derivative ends the newton loop early.
// one item at a time: busy is high from the accept until the result strobe, so
// no new item is taken before the last result is out; the receiver cannot stall.
// reset is asynchronous, active low, and returns the sequencer to idle.
// ----------------------------------------------------------------------------
// cubic_bezier_ease_eval
// cubic bezier ease curve, x(s)=t solved by newton steps, returns y(s)
// ----------------------------------------------------------------------------
`default_nettype none

`include "cubic_bezier_ease_eval_macros.svh"

module cubic_bezier_ease_eval
#(
    parameter int NEWTON_STEPS = 6
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [17:0] progress,
    output logic                    busy,
    output logic                    done,
    output logic [15:0]             eased
);
    import cbee_pkg::*;

    localparam int IW = $clog2(NEWTON_STEPS + 1);
    localparam logic signed [PW-1:0] P_ONE = PW'(1) << FRAC_BITS;
    localparam logic [SW:0] OHALF = (SW+1)'(1) << (IQ - FRAC_BITS - 1);
    localparam int SHW = NW + 2;

    state_t                 state_reg, state_next;
    poly_t                  poly_reg,  poly_next;
    logic [1:0]             k_reg,     k_next;
    logic [IW-1:0]          iter_reg,  iter_next;
    logic [SW-1:0]          t_reg,     t_next;
    logic [SW-1:0]          s_reg,     s_next;
    logic signed [AW-1:0]   acc_reg,   acc_next;
    logic signed [AW-1:0]   d_reg,     d_next;
    logic [15:0]            eased_reg, eased_next;
    logic                   done_reg,  done_next;

    logic                   mul_en;
    logic signed [AW-1:0]   prod;
    logic                   div_start;
    logic                   div_done;
    logic signed [NW:0]     quo;

    logic signed [PW-1:0]   p_ext;
    logic signed [PW-1:0]   p_cl;
    logic signed [SHW-1:0]  s_sub;
    logic [SW-1:0]          s_cl;
    logic [SW-1:0]          y_cl;
    logic [SW:0]            y_rnd;

    // shared multiplier and serial divider
    cbee_mul u_mul
    (
        .clk  (clk),
        .en   (mul_en),
        .a    (acc_reg),
        .b    (s_reg),
        .prod (prod)
    );

    cbee_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (d_reg),
        .den   (acc_reg),
        .done  (div_done),
        .quo   (quo)
    );

    // input clamp, newton update clamp, output clamp and rounding
    always_comb
    begin
        p_ext = PW'(progress);
        p_cl  = p_ext;
        if (p_ext < 0)
        begin
            p_cl = '0;
        end
        else if (p_ext > P_ONE)
        begin
            p_cl = P_ONE;
        end

        s_sub = $signed({{(SHW-SW){1'b0}}, s_reg}) - SHW'(quo);
        if (s_sub < 0)
        begin
            s_cl = '0;
        end
        else if (s_sub > $signed(SHW'(S_ONE)))
        begin
            s_cl = S_ONE;
        end
        else
        begin
            s_cl = s_sub[SW-1:0];
        end

        if (acc_reg < 0)
        begin
            y_cl = '0;
        end
        else if (acc_reg > $signed(AW'(S_ONE)))
        begin
            y_cl = S_ONE;
        end
        else
        begin
            y_cl = acc_reg[SW-1:0];
        end
        y_rnd = ((SW+1)'(y_cl) + OHALF) >> (IQ - FRAC_BITS);
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        poly_next  = poly_reg;
        k_next     = k_reg;
        iter_next  = iter_reg;
        t_next     = t_reg;
        s_next     = s_reg;
        acc_next   = acc_reg;
        d_next     = d_reg;
        eased_next = eased_reg;
        done_next  = 1'b0;
        mul_en     = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    t_next     = SW'(p_cl) << (IQ - FRAC_BITS);
                    s_next     = SW'(p_cl) << (IQ - FRAC_BITS);
                    iter_next  = '0;
                    poly_next  = POLY_X;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                acc_next   = lead_coef(poly_reg);
                k_next     = '0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                mul_en     = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                acc_next = prod + add_coef(poly_reg, k_reg);
                k_next   = k_reg + 2'd1;
                if (k_reg == last_step(poly_reg))
                begin
                    state_next = ST_POST;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_POST:
            begin
                case (poly_reg)
                    POLY_X:
                    begin
                        d_next     = acc_reg - $signed(AW'(t_reg));
                        poly_next  = POLY_DX;
                        state_next = ST_LOAD;
                    end
                    POLY_DX:
                    begin
                        // flat derivative ends the newton loop
                        if (acc_reg == '0)
                        begin
                            poly_next  = POLY_Y;
                            state_next = ST_LOAD;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                    end
                    default:
                    begin
                        eased_next = y_rnd[15:0];
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                s_next     = s_cl;
                iter_next  = iter_reg + IW'(1);
                state_next = ST_LOAD;
                if (iter_reg == IW'(NEWTON_STEPS - 1))
                begin
                    poly_next = POLY_Y;
                end
                else
                begin
                    poly_next = POLY_X;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            poly_reg  <= POLY_X;
            k_reg     <= '0;
            iter_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            poly_reg  <= poly_next;
            k_reg     <= k_next;
            iter_reg  <= iter_next;
            done_reg  <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        t_reg     <= t_next;
        s_reg     <= s_next;
        acc_reg   <= acc_next;
        d_reg     <= d_next;
        eased_reg <= eased_next;
    end

    assign busy  = (state_reg != ST_IDLE);
    assign done  = done_reg;
    assign eased = eased_reg;

    // checks
    `CBEE_ASSERT(a_done_single, clk, rst_n, done_reg |=> !done_reg)
    `CBEE_ASSERT(a_accept_busy, clk, rst_n, (start && !busy) |=> busy)
    `CBEE_ASSERT(a_eased_range, clk, rst_n, done_reg |-> (eased_reg <= 16'(P_ONE)))
    `CBEE_ASSERT(a_s_unit, clk, rst_n, (state_reg != ST_IDLE) |-> (s_reg <= S_ONE))
    `CBEE_ASSERT(a_div_only_wait, clk, rst_n, div_done |-> (state_reg == ST_DIV))
    `CBEE_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !done_reg)

endmodule

`default_nettype wire

// ----- tb/cubic_bezier_ease_eval_test.sv -----
// ----------------------------------------------------------------------------
// cubic_bezier_ease_eval_test
// drives progress items into the easing evaluator, checks each eased result
// against a table value or a fixed-point predictor of newton solve and y(s)
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_bezier_ease_eval_test;

    import cbee_pkg::*;

    localparam int RANDOM_ITEMS = 1530;
    localparam int SETTLE_CYCLES = 600;

    localparam logic signed [63:0] Q_ONE = 64'sd1 << 30;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic signed [17:0] progress;
    logic               busy;
    logic               done;
    logic [15:0]        eased;

    logic [15:0] eased_due[$];
    int          mismatch_count;

    // directed table: progress value and the eased value where it is obvious
    typedef struct {
        logic signed [17:0] value;
        bit                 known;
        logic [15:0]        eased_known;
    } row_t;

    row_t rows[$];

    cubic_bezier_ease_eval dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .progress (progress),
        .busy     (busy),
        .done     (done),
        .eased    (eased)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    initial
    begin
        #40000000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [63:0] magnitude(input logic signed [63:0] a);
        return a < 0 ? 64'(-a) : 64'(a);
    endfunction

    // q33.30 product, rounded half away from zero
    function automatic logic signed [63:0] q_mul(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
        logic [63:0] r;
        r = (magnitude(a) * magnitude(b) + (64'd1 << 29)) >> 30;
        return ((a < 0) != (b < 0)) ? -$signed(r) : $signed(r);
    endfunction

    // newton quotient, residual saturated at 4.0
    function automatic logic signed [63:0] q_div(input logic signed [63:0] n,
                                                 input logic signed [63:0] d);
        logic [63:0] un;
        logic [63:0] ud;
        logic [63:0] r;
        un = magnitude(n);
        ud = magnitude(d);
        if (un > (64'd4 << 30))
            un = 64'd4 << 30;
        r = ((un << 30) + (ud >> 1)) / ud;
        return ((n < 0) != (d < 0)) ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [63:0] unit_clamp(input logic signed [63:0] v);
        return v < 0 ? 64'sd0 : (v > Q_ONE ? Q_ONE : v);
    endfunction

    // expected eased value for one progress item
    function automatic logic [15:0] ease_of(input logic signed [17:0] p_in);
        logic signed [63:0] t;
        logic signed [63:0] s;
        logic signed [63:0] d;
        logic signed [63:0] dx;
        logic signed [63:0] y;
        logic signed [63:0] k[9];
        logic [63:0]        r;
        bit                 stop;
        k[0] = KX1; k[1] = KX2; k[2] = KX3;
        k[3] = KD0; k[4] = KD1; k[5] = KD2;
        k[6] = KY1; k[7] = KY2; k[8] = KY3;
        t = p_in;
        if (t < 0)
            t = 0;
        if (t > 64'sd32768)
            t = 64'sd32768;
        t = t <<< 15;
        s = t;
        stop = 0;
        for (int i = 0; i < 6; i++)
        begin
            if (!stop)
            begin
                d = q_mul(q_mul(q_mul(k[2], s) + k[1], s) + k[0], s) - t;
                dx = q_mul(q_mul(k[5], s) + k[4], s) + k[3];
                if (dx == 0)
                    stop = 1;
                else
                    s = unit_clamp(s - q_div(d, dx));
            end
        end
        y = unit_clamp(q_mul(q_mul(q_mul(k[8], s) + k[7], s) + k[6], s));
        r = (64'(y) + (64'd1 << 14)) >> 15;
        return r[15:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch %s: eased got %0d want %0d at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    task automatic idle_burst();
        repeat ($urandom_range(13, 1)) @(posedge clk);
    endtask

    // one item: wait for not busy, then hold start for the accepting edge
    task automatic send_item(input logic signed [17:0] value, input bit known,
                             input logic [15:0] want);
        while (busy)
            @(posedge clk);
        eased_due.push_back(known ? want : ease_of(value));
        start <= 1'b1;
        progress <= value;
        @(posedge clk);
        start <= 1'b0;
        progress <= 18'($urandom);
        // busy rises after the accept; the next item waits for it to clear
        @(posedge clk);
    endtask

    // result check
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (eased_due.size() == 0)
                report_mismatch("unexpected", eased, 16'd0);
            else
            begin
                if (eased !== eased_due[0])
                    report_mismatch("value", eased, eased_due[0]);
                void'(eased_due.pop_front());
            end
        end
    end

    function automatic row_t mk(input logic signed [17:0] v, input bit kn,
                                input logic [15:0] e);
        row_t r;
        r.value = v;
        r.known = kn;
        r.eased_known = e;
        return r;
    endfunction

    // stimulus
    initial
    begin
        logic signed [17:0] v;
        int                 sel;
        start = 1'b0;
        progress = '0;
        rst_n = 1'b0;
        mismatch_count = 0;
        // extremes, clamps, ends of the curve and a few midpoints
        rows.push_back(mk(18'sd0, 1, 16'd0));
        rows.push_back(mk(18'sd32768, 1, 16'd32768));
        rows.push_back(mk(-18'sd131072, 1, 16'd0));
        rows.push_back(mk(18'sd131071, 1, 16'd32768));
        rows.push_back(mk(-18'sd1, 1, 16'd0));
        rows.push_back(mk(18'sd32769, 1, 16'd32768));
        rows.push_back(mk(18'sd65536, 1, 16'd32768));
        rows.push_back(mk(18'sd1, 0, 0));
        rows.push_back(mk(18'sd2, 0, 0));
        rows.push_back(mk(18'sd32767, 0, 0));
        rows.push_back(mk(18'sd32766, 0, 0));
        rows.push_back(mk(18'sd16384, 0, 0));
        rows.push_back(mk(18'sd8192, 0, 0));
        rows.push_back(mk(18'sd24576, 0, 0));
        rows.push_back(mk(18'sd10923, 0, 0));
        rows.push_back(mk(18'sd21845, 0, 0));
        rows.push_back(mk(18'sd4096, 0, 0));
        rows.push_back(mk(18'sd21627, 0, 0));
        rows.push_back(mk(18'sd43690, 0, 0));
        rows.push_back(mk(-18'sd43691, 0, 0));
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (rows[i])
            send_item(rows[i].value, rows[i].known, rows[i].eased_known);
        // let everything drain once before the random part
        while (eased_due.size() != 0)
            @(posedge clk);
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            sel = $urandom_range(9, 0);
            if (sel < 7)
                v = 18'($urandom_range(32768, 0));
            else if (sel < 9)
                v = 18'($urandom);
            else
                v = 18'($urandom_range(40, 0)) + ($urandom_range(1, 0) ? 18'sd32728 : 18'sd0);
            if (n < RANDOM_ITEMS - 100 && $urandom_range(3, 0) == 0)
                idle_burst();
            send_item(v, 0, 0);
        end
        while (eased_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && eased_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
